### sv/pkot_pkg.sv
`timescale 1ns / 1ps
// Package: table geometry, item codes, controller states and command/status structs.
package pkot_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W   = 8;
	localparam int VAL_W   = 8;
	localparam int KIND_W  = 2;
	localparam int ENTRY_W = 2 * KEY_W + VAL_W;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} dp_stat_t;

endpackage

### sv/pkot_ifs.sv
`timescale 1ns / 1ps
// Interfaces: item channel and result channel with valid/ready handshake.
interface pkot_in_if;
	import pkot_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  attack_key;
	logic [KEY_W-1:0]  defend_key;
	logic [VAL_W-1:0]  value_in;

	modport source (output valid, output kind, output attack_key, output defend_key,
		output value_in, input ready);
	modport sink (input valid, input kind, input attack_key, input defend_key,
		input value_in, output ready);
endinterface

interface pkot_out_if;
	import pkot_pkg::*;
	logic             valid;
	logic             ready;
	logic             found;
	logic [VAL_W-1:0] value_out;
	logic             dropped;

	modport source (output valid, output found, output value_out, output dropped,
		input ready);
	modport sink (input valid, input found, input value_out, input dropped,
		output ready);
endinterface

### sv/pkot_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module pkot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### sv/pkot_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accept, table scan and result load.
module pkot_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic [pkot_pkg::KIND_W-1:0] req_kind,
	output logic                    ready,
	input  pkot_pkg::dp_stat_t      stat,
	output pkot_pkg::ctl_cmd_t      cmd
);
	import pkot_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					// clear and unused codes need no scan
					if (req_kind inside {KIND_SET, KIND_LOOKUP}) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ready      = (state_q == ST_IDLE);
		cmd.start  = (state_q == ST_IDLE) && req_valid;
		cmd.finish = (state_q == ST_FINISH) && !stat.out_busy;
	end
endmodule

### sv/pkot_dp.sv
`timescale 1ns / 1ps
// Datapath: item registers, valid bits, content RAM, scan stage and result register.
module pkot_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pkot_pkg::ctl_cmd_t           cmd,
	output pkot_pkg::dp_stat_t           stat,
	input  logic [pkot_pkg::KIND_W-1:0]  kind,
	input  logic [pkot_pkg::KEY_W-1:0]   attack_key,
	input  logic [pkot_pkg::KEY_W-1:0]   defend_key,
	input  logic [pkot_pkg::VAL_W-1:0]   value_in,
	pkot_out_if.source                   rsp
);
	import pkot_pkg::*;

	logic [KIND_W-1:0]  kind_q;
	logic [KEY_W-1:0]   akey_q;
	logic [KEY_W-1:0]   dkey_q;
	logic [VAL_W-1:0]   val_q;

	logic [ENTRIES-1:0] valid_q;

	logic [IDX_W-1:0]   scan_idx_q;
	logic               issuing_q;

	logic               act_s1;
	logic               last_s1;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               have_match_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [VAL_W-1:0]   match_val_q;
	logic               have_free_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic               out_valid_q;
	logic               found_q;
	logic [VAL_W-1:0]   value_q;
	logic               dropped_q;

	logic [ENTRY_W-1:0] rd_data;
	logic               hit_s1;
	logic               is_set;
	logic               is_lookup;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;

	pkot_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wdata({akey_q, dkey_q, val_q}),
		.re   (issuing_q),
		.raddr(scan_idx_q),
		.rdata(rd_data)
	);

	assign is_set    = (kind_q == KIND_SET);
	assign is_lookup = (kind_q == KIND_LOOKUP);
	assign hit_s1    = act_s1 && vld_s1 && (rd_data[ENTRY_W-1:VAL_W] == {akey_q, dkey_q});
	// an existing match always wins over a free entry
	assign wr_idx    = have_match_q ? match_idx_q : free_idx_q;
	assign wr_en     = cmd.finish && is_set && (have_match_q || have_free_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			akey_q <= attack_key;
			dkey_q <= defend_key;
			val_q  <= value_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.finish && (kind_q == KIND_CLEAR)) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q  <= 1'b0;
			scan_idx_q <= '0;
		end else if (cmd.start) begin
			issuing_q  <= (kind == KIND_SET) || (kind == KIND_LOOKUP);
			scan_idx_q <= '0;
		end else if (issuing_q) begin
			if (scan_idx_q == LAST_IDX) begin
				issuing_q <= 1'b0;
			end else begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= issuing_q;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= (scan_idx_q == LAST_IDX);
		vld_s1  <= valid_q[scan_idx_q];
		idx_s1  <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_match_q <= 1'b0;
			have_free_q  <= 1'b0;
		end else if (cmd.start) begin
			have_match_q <= 1'b0;
			have_free_q  <= 1'b0;
		end else begin
			if (hit_s1 && !have_match_q) begin
				have_match_q <= 1'b1;
			end
			if (act_s1 && !vld_s1 && !have_free_q) begin
				have_free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1 && !have_match_q) begin
			match_idx_q <= idx_s1;
			match_val_q <= rd_data[VAL_W-1:0];
		end
		// keep the lowest free entry
		if (act_s1 && !vld_s1 && !have_free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q   <= is_lookup && have_match_q;
			value_q   <= (is_lookup && have_match_q) ? match_val_q : '0;
			dropped_q <= is_set && !have_match_q && !have_free_q;
		end
	end

	assign stat.scan_last = act_s1 && last_s1;
	assign stat.out_busy  = out_valid_q && !rsp.ready;

	assign rsp.valid     = out_valid_q;
	assign rsp.found     = found_q;
	assign rsp.value_out = value_q;
	assign rsp.dropped   = dropped_q;
endmodule

### sv/pair_keyed_override_table.sv
`timescale 1ns / 1ps
// Set and lookup scan every table entry before the result is loaded; clear and the unused
// code load their result without a scan. A result held by a low ready delays the next result load.
// Throughput: one item at a time; the scan reads one table entry per cycle through the
// single read port of the content RAM.
// Reset: valid bits clear at once (all entries free); RAM content is not cleared.
module pair_keyed_override_table (
	input  logic       clk,
	input  logic       arst_n,
	pkot_in_if.sink    req,
	pkot_out_if.source rsp
);
	import pkot_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic     ready;

	assign req.ready = ready;

	pkot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_kind (req.kind),
		.ready    (ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pkot_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (req.kind),
		.attack_key(req.attack_key),
		.defend_key(req.defend_key),
		.value_in  (req.value_in),
		.rsp       (rsp)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item taken while one is in work");

	a_found_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.found && rsp.dropped))
		else $error("result flags both a hit and a dropped set");

	a_miss_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.value_out == '0))
		else $error("value present without a lookup hit");

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(rsp.valid && !rsp.ready))
		else $error("result register overwritten before transfer");
endmodule
